// File: rtl/device_address_dedup_table_unit_defines.svh
// Assertion macros shared by the device address dedup table RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DEVICE_ADDRESS_DEDUP_TABLE_UNIT_DEFINES_SVH
`define DEVICE_ADDRESS_DEDUP_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DADT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dedup table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DADT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dedup table: next-cycle check failed");

`endif

// File: rtl/dadt_pkg.sv
// Package for the device address dedup table: payload structs, command codes,
// controller/datapath interface structs. Depends on nothing.
package dadt_pkg;

    localparam int ADDR_BITS = 48;
    localparam int SIG_BITS  = 8;
    localparam int TICK_BITS = 32;
    localparam int IDX_BITS  = 6;

    localparam logic [1:0] CMD_UPSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [ADDR_BITS-1:0]       dev_addr;
        logic signed [SIG_BITS-1:0] signal_dbm;
        logic [TICK_BITS-1:0]       now_ms;
        logic [IDX_BITS-1:0]        read_index;
        logic [IDX_BITS-1:0]        read_limit;
    } t_dadt_in;

    typedef struct packed {
        logic                       found;
        logic                       stored;
        logic [IDX_BITS-1:0]        slot;
        logic [IDX_BITS-1:0]        entry_count;
        logic                       out_valid;
        logic [ADDR_BITS-1:0]       out_addr;
        logic signed [SIG_BITS-1:0] out_signal;
        logic [TICK_BITS-1:0]       out_seen_ms;
    } t_dadt_out;

    // One table entry as held in the RAM.
    typedef struct packed {
        logic [ADDR_BITS-1:0]       addr;
        logic signed [SIG_BITS-1:0] signal_dbm;
        logic [TICK_BITS-1:0]       seen_ms;
    } t_dadt_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic set_hit;
        logic set_miss;
        logic write_entry;
        logic clear;
        logic load_out;
    } t_dadt_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_upsert;
        logic is_clear;
        logic count_zero;
        logic scan_end;
        logic match;
        logic out_free;
    } t_dadt_stat;

endpackage

// File: rtl/device_address_dedup_table_unit.sv
// Top level of the device address dedup table: controller plus datapath.
// Depends on dadt_pkg, dadt_ctrl, dadt_dpath and the assertion macro header.
//
// This block keeps a table of up to TABLE_DEPTH seen radio devices keyed by
// their 48-bit address and handles one item at a time. An upsert searches
// the filled entries in index order through the single read port of the
// entry RAM, one entry per cycle, refreshes the first matching entry or
// appends a new one, and drops the report when the table is full. Reads,
// clears and the unused command go straight from dispatch to the result
// step without a search. Every item produces exactly one result transfer.
// The result sits in an output register, so a new item is taken while the
// previous result still waits for the consumer; only the final result step
// waits for that register to drain. Entry storage has no reset; only entries
// below the fill count are ever returned.
`include "device_address_dedup_table_unit_defines.svh"

module device_address_dedup_table_unit #(
    parameter int TABLE_DEPTH = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dadt_pkg::t_dadt_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dadt_pkg::t_dadt_out o_out_data
);

    // Commands and status between the controller and the datapath.
    dadt_pkg::t_dadt_cmd  s_cmd;
    dadt_pkg::t_dadt_stat s_stat;

    // The controller sequences dispatch, the entry search, the write-back
    // and the hand-off of the result to the output register.
    dadt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // The datapath holds the item, the fill count, the search index, the
    // entry RAM and the output register.
    dadt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // An accepted item keeps the block busy for at least the next cycle.
    `DADT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // The result is only moved into the output register when it has room.
    `DADT_ASSERT_IMPL(a_load_only_when_free, i_clk, i_rst_n, s_cmd.load_out, s_stat.out_free)

    // The reported fill count never exceeds the table depth.
    `DADT_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, (TABLE_DEPTH < 64) && o_out_valid, o_out_data.entry_count <= 6'(TABLE_DEPTH))

endmodule

// File: rtl/dadt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dadt_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/dadt_ctrl.sv
// Controller state machine of the device address dedup table.
// Depends on dadt_pkg for the command and status structs and command codes.
module dadt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dadt_pkg::t_dadt_stat i_stat,
    output dadt_pkg::t_dadt_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_RESULT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.is_upsert) begin
                    if (i_stat.count_zero) begin
                        o_cmd.set_miss = 1'b1;
                        n_state        = ST_WRITE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_SCAN;
                    end
                end else begin
                    // A read has its RAM address presented in this cycle.
                    o_cmd.clear = i_stat.is_clear;
                    n_state     = ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = ST_WRITE;
                end else if (i_stat.scan_end) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = ST_WRITE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state           = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: rtl/dadt_dpath.sv
// Datapath of the device address dedup table: item register, fill count,
// scan index, entry RAM and output register. Depends on dadt_pkg and dadt_ram.
module dadt_dpath #(
    parameter int TABLE_DEPTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dadt_pkg::t_dadt_in   i_in_data,
    input  dadt_pkg::t_dadt_cmd  i_cmd,
    output dadt_pkg::t_dadt_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dadt_pkg::t_dadt_out  o_out_data
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = ((CNT_W > dadt_pkg::IDX_BITS) ? CNT_W : dadt_pkg::IDX_BITS) + 1;
    localparam int ENT_W  = $bits(dadt_pkg::t_dadt_entry);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(TABLE_DEPTH);

    dadt_pkg::t_dadt_in    r_item;
    dadt_pkg::t_dadt_out   r_out;
    dadt_pkg::t_dadt_out   n_out;
    dadt_pkg::t_dadt_entry s_rd_entry;
    dadt_pkg::t_dadt_entry s_wr_entry;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_idx;
    logic [AW-1:0]         r_cmp;
    logic [AW-1:0]         r_slot;
    logic                  r_found;
    logic                  r_stored;
    logic                  r_out_valid;
    logic [AW-1:0]         s_rd_addr;
    logic [ENT_W-1:0]      s_rd_data;
    logic                  s_is_read;
    logic [CMP_W-1:0]      s_ridx;
    logic [CMP_W-1:0]      s_rlim;
    logic [CMP_W-1:0]      s_cnt;
    logic [CMP_W-1:0]      s_lim;
    logic                  s_read_hit;

    assign s_is_read = (r_item.cmd == dadt_pkg::CMD_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.write_entry && r_stored && !r_found) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_data;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_stored <= 1'b0;
            r_slot   <= '0;
        end
        if (i_cmd.step) begin
            r_cmp <= r_idx[AW-1:0];
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.set_hit) begin
            r_found  <= 1'b1;
            r_stored <= 1'b1;
            r_slot   <= r_cmp;
        end
        if (i_cmd.set_miss && (r_count != FULL_CNT)) begin
            r_stored <= 1'b1;
            r_slot   <= r_count[AW-1:0];
        end
    end

    assign s_rd_addr = s_is_read ? AW'(r_item.read_index) : r_idx[AW-1:0];

    assign s_wr_entry.addr       = r_item.dev_addr;
    assign s_wr_entry.signal_dbm = r_item.signal_dbm;
    assign s_wr_entry.seen_ms    = r_item.now_ms;

    dadt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write_entry && r_stored),
        .i_wr_addr (r_slot),
        .i_wr_data (s_wr_entry),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    assign s_rd_entry = s_rd_data;

    // A read hits when its index lies below both the fill count and the limit.
    assign s_ridx     = CMP_W'(r_item.read_index);
    assign s_rlim     = CMP_W'(r_item.read_limit);
    assign s_cnt      = CMP_W'(r_count);
    assign s_lim      = (s_cnt < s_rlim) ? s_cnt : s_rlim;
    assign s_read_hit = (s_ridx < s_lim) && (s_ridx < DEPTH_CMP);

    always_comb begin
        n_out             = '0;
        n_out.entry_count = dadt_pkg::IDX_BITS'(r_count);
        case (r_item.cmd)
            dadt_pkg::CMD_UPSERT: begin
                n_out.found  = r_found;
                n_out.stored = r_stored;
                n_out.slot   = dadt_pkg::IDX_BITS'(r_slot);
            end
            dadt_pkg::CMD_READ: begin
                n_out.slot      = r_item.read_index;
                n_out.out_valid = s_read_hit;
                if (s_read_hit) begin
                    n_out.out_addr    = s_rd_entry.addr;
                    n_out.out_signal  = s_rd_entry.signal_dbm;
                    n_out.out_seen_ms = s_rd_entry.seen_ms;
                end
            end
            default: begin
                n_out.slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_stat.is_upsert  = (r_item.cmd == dadt_pkg::CMD_UPSERT);
    assign o_stat.is_clear   = (r_item.cmd == dadt_pkg::CMD_CLEAR);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.scan_end   = (r_idx == r_count);
    assign o_stat.match      = (s_rd_entry.addr == r_item.dev_addr);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
